FILE: rtl/uint_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of the decimal converter.
`ifndef UINT_TO_DECIMAL_ASCII_ASSERT_SVH
`define UINT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define U2DA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define U2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/u2da_pkg.sv
// Types and constants shared by the decimal ASCII converter modules.
package u2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int CNT_W      = 5;
    localparam int CHAR_W     = 6;
    localparam int BCD_DIGITS = 10;
    localparam int DIG_IDX_W  = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    localparam logic CMD_MINIMAL = 1'b0;
    localparam logic CMD_FIXED   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   digit_count;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic [CNT_W-1:0]  total_length;
    } out_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic size;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic idx_zero;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/u2da_dp.sv
// Datapath: operand capture, shift-add-3 BCD conversion, length and character output.
module u2da_dp #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  u2da_pkg::in_t         s_data,
    input  u2da_pkg::dp_cmd_t     cmd,
    output u2da_pkg::dp_status_t  status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u2da_pkg::out_t        m_data
);
    import u2da_pkg::*;

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_DIGITS);

    logic [VALUE_W-1:0]              val_reg, val_next;
    logic [BCD_DIGITS-1:0][3:0]      bcd_reg, bcd_next, bcd_adj;
    logic [BCD_DIGITS*4-1:0]         bcd_flat;
    logic                            mode_reg;
    logic [CNT_W-1:0]                req_reg, req_clamped;
    logic [CNT_W-1:0]                len_reg, len_next, sig_len;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic                            m_valid_reg, m_valid_next;
    out_t                            out_reg, out_next;
    logic [3:0]                      dsel;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign bcd_flat = bcd_adj;

    always_comb begin
        sig_len = CNT_W'(1);
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                sig_len = CNT_W'(i + 1);
            end
        end
    end

    assign req_clamped = (s_data.digit_count > MAX_LEN) ? MAX_LEN : s_data.digit_count;

    always_comb begin
        if (idx_reg < CNT_W'(BCD_DIGITS)) begin
            dsel = bcd_reg[idx_reg[DIG_IDX_W-1:0]];
        end else begin
            dsel = 4'd0;
        end
    end

    always_comb begin
        val_next     = val_reg;
        bcd_next     = bcd_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load) begin
            val_next = s_data.value;
            bcd_next = '0;
        end
        if (cmd.shift) begin
            bcd_next = {bcd_flat[BCD_DIGITS*4-2:0], val_reg[VALUE_W-1]};
            val_next = {val_reg[VALUE_W-2:0], 1'b0};
        end
        if (cmd.size) begin
            len_next = (mode_reg == CMD_FIXED) ? req_reg : sig_len;
            idx_next = len_next - CNT_W'(1);
        end
        if (cmd.emit) begin
            out_next.digit_char   = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, dsel};
            out_next.last         = (idx_reg == '0);
            out_next.total_length = len_reg;
            m_valid_next          = 1'b1;
            idx_next              = idx_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        val_reg <= val_next;
        bcd_reg <= bcd_next;
        len_reg <= len_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
        if (cmd.load) begin
            mode_reg <= s_data.cmd;
            req_reg  <= req_clamped;
        end
    end

    assign status.len_zero = (len_reg == '0);
    assign status.idx_zero = (idx_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

endmodule

FILE: rtl/u2da_ctrl.sv
// Controller: sequences capture, conversion steps, sizing and character output.
module u2da_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output u2da_pkg::dp_cmd_t     cmd,
    input  u2da_pkg::dp_status_t  status
);
    import u2da_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load     = s_valid;
                bit_cnt_next = '0;
                if (s_valid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift    = 1'b1;
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free && !status.len_zero;
                if (status.len_zero || (status.out_free && status.idx_zero)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/uint_to_decimal_ascii.sv
// Unsigned 32-bit binary to decimal ASCII converter, top level.
// Each accepted value is converted by a serial shift-add-3 loop, one input bit per
// clock, then sized, then streamed out one character per cycle while the output
// is not stalled, most significant digit first. The next value is taken while the
// final character still waits in the output register.
// Minimal mode gives the digits without leading zeros ("0" for zero); fixed mode
// gives exactly digit_count low digits (clamped to MAX_DIGITS), zero-padded, and
// nothing at all for a count of zero.
module uint_to_decimal_ascii #(
    parameter int MAX_DIGITS = 20
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  u2da_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output u2da_pkg::out_t  m_data
);
    import u2da_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    u2da_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    u2da_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/u2da_checker.sv
// Port-level checks for the decimal ASCII converter, bound to its top level.
`include "uint_to_decimal_ascii_assert.svh"

module u2da_checker #(
    parameter int MAX_DIGITS = 20
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input u2da_pkg::in_t   s_data,
    input logic            m_valid,
    input logic            m_ready,
    input u2da_pkg::out_t  m_data
);
    import u2da_pkg::*;

    `U2DA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled transaction changed")
    `U2DA_ASSERT_IMPL(a_busy_mid_string, m_valid && !m_data.last, !s_ready, "input taken mid string")
    `U2DA_ASSERT_IMPL(a_digit_range, m_valid, (m_data.digit_char >= 6'd48) && (m_data.digit_char <= 6'd57), "non-digit character")
    `U2DA_ASSERT_IMPL(a_len_range, m_valid, (m_data.total_length != '0) && (m_data.total_length <= CNT_W'(MAX_DIGITS)), "bad total length")
    `U2DA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second input taken during conversion")

endmodule

bind uint_to_decimal_ascii u2da_checker #(.MAX_DIGITS(MAX_DIGITS)) u_chk (.*);
